>>> hw/rtl/page_table_walk_short_descriptor_macros.svh
// assertion macros shared by the walker's checker
// expects clk and arst_n in the scope where a macro is used
`ifndef PAGE_TABLE_WALK_SHORT_DESCRIPTOR_MACROS_SVH
`define PAGE_TABLE_WALK_SHORT_DESCRIPTOR_MACROS_SVH

// same-cycle implication
`define PTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ptw_pkg.sv
// shared types and constants of the short-descriptor table walker
// used by the controller, the datapath, the top level and the checker
package ptw_pkg;

	localparam int unsigned STORE_WORDS_DEF = 16384;
	localparam int unsigned L1_BASE_W       = 14;
	localparam int unsigned WIDX_W          = 14;
	localparam int unsigned CFG_AW          = 3;

	// register index taken from paddr[CFG_AW-1:2]
	localparam logic [CFG_AW-3:0] REG_L1_BASE = 1'b0;

	typedef enum logic {
		OP_WRITE     = 1'b0,
		OP_TRANSLATE = 1'b1
	} ptw_op_t;

	typedef enum logic [2:0] {
		KIND_FAULT   = 3'd0,
		KIND_SUPER   = 3'd1,
		KIND_SECTION = 3'd2,
		KIND_LARGE   = 3'd3,
		KIND_SMALL   = 3'd4
	} ptw_kind_t;

	typedef struct packed {
		ptw_op_t            op;
		logic [WIDX_W-1:0]  word_index;
		logic [31:0]        write_data;
		logic [31:0]        virt_addr;
	} ptw_in_t;

	typedef struct packed {
		logic [31:0] phys_addr;
		ptw_kind_t   map_kind;
		logic        fault;
	} ptw_out_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic wr;
		logic rd_l1;
		logic rd_l2;
		logic capture;
	} ptw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic need_l2;
	} ptw_sts_t;

endpackage

>>> hw/rtl/ptw_ctrl.sv
// walk sequencer: clear sweep, level one and level two reads, result handoff
// depends on ptw_pkg
module ptw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  ptw_pkg::ptw_op_t  req_op,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ptw_pkg::ptw_cmd_t cmd,
	input  ptw_pkg::ptw_sts_t sts
);
	import ptw_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_L1,
		ST_L2,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	always_comb begin
		out_free    = !rsp_valid_q || rsp_ready;
		req_ready   = (state_q == ST_IDLE);
		accept      = req_valid && req_ready;
		cmd.clr     = (state_q == ST_CLEAR);
		cmd.wr      = accept && (req_op == OP_WRITE);
		cmd.rd_l1   = accept && (req_op == OP_TRANSLATE);
		cmd.rd_l2   = (state_q == ST_L1) && sts.need_l2;
		cmd.capture = out_free && (((state_q == ST_L1) && !sts.need_l2) ||
			(state_q == ST_L2) || (state_q == ST_FIN));
	end

	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.rd_l1) state_q <= ST_L1;
				end
				ST_L1: begin
					if (sts.need_l2) state_q <= ST_L2;
					else if (out_free) state_q <= ST_IDLE;
					else state_q <= ST_FIN;
				end
				ST_L2: begin
					state_q <= out_free ? ST_IDLE : ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

>>> hw/rtl/ptw_dp.sv
// descriptor memory, walk address generation and result formatting
// depends on ptw_pkg; STORE_WORDS must be a power of two
module ptw_dp #(
	parameter int unsigned STORE_WORDS = ptw_pkg::STORE_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptw_pkg::ptw_cmd_t              cmd,
	input  ptw_pkg::ptw_in_t               req,
	input  logic [ptw_pkg::L1_BASE_W-1:0]  l1_base,
	output ptw_pkg::ptw_sts_t              sts,
	output ptw_pkg::ptw_out_t              rsp
);
	import ptw_pkg::*;

	localparam int unsigned AW   = $clog2(STORE_WORDS);
	localparam int unsigned SUMW = (AW > L1_BASE_W + 1) ? AW : L1_BASE_W + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(STORE_WORDS - 1);

	logic [31:0]   mem [STORE_WORDS];
	logic [AW-1:0] clr_idx_q;
	logic [31:0]   rdata_q;
	logic [31:0]   va_q;
	logic          lvl2_q;
	ptw_out_t      rsp_q;

	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;
	logic [SUMW-1:0] l1_sum;
	logic [29:0]   l2_word;
	ptw_out_t      res;

	always_comb begin
		wr_idx  = cmd.clr ? clr_idx_q : AW'(req.word_index);
		l1_sum  = SUMW'(l1_base) + SUMW'(req.virt_addr[31:20]);
		// byte address of the level two entry, shifted down to a word index
		l2_word = {rdata_q[31:10], va_q[19:12]};
		rd_idx  = cmd.rd_l2 ? AW'(l2_word) : AW'(l1_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr || cmd.wr) begin
			mem[wr_idx] <= cmd.clr ? 32'd0 : req.write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_l1 || cmd.rd_l2) begin
			rdata_q <= mem[rd_idx];
		end
		if (cmd.rd_l1) begin
			va_q   <= req.virt_addr;
			lvl2_q <= 1'b0;
		end else if (cmd.rd_l2) begin
			lvl2_q <= 1'b1;
		end
		if (cmd.capture) begin
			rsp_q <= res;
		end
	end

	always_comb begin
		res.phys_addr = '0;
		res.map_kind  = KIND_FAULT;
		if (!lvl2_q) begin
			if (rdata_q[1]) begin
				if (rdata_q[18]) begin
					res.phys_addr = {rdata_q[31:24], va_q[23:0]};
					res.map_kind  = KIND_SUPER;
				end else begin
					res.phys_addr = {rdata_q[31:20], va_q[19:0]};
					res.map_kind  = KIND_SECTION;
				end
			end
		end else if (rdata_q[1]) begin
			res.phys_addr = {rdata_q[31:12], va_q[11:0]};
			res.map_kind  = KIND_SMALL;
		end else if (rdata_q[0]) begin
			res.phys_addr = {rdata_q[31:16], va_q[15:0]};
			res.map_kind  = KIND_LARGE;
		end
		res.fault = (res.map_kind == KIND_FAULT);
	end

	assign sts.clr_last = (clr_idx_q == LAST_IDX);
	// coarse page table pointer at level one
	assign sts.need_l2  = !rdata_q[1] && rdata_q[0];
	assign rsp          = rsp_q;

endmodule

>>> hw/rtl/page_table_walk_short_descriptor.sv
// Short-descriptor translation table walker, top level.
// Request channel (req_valid/req_ready/req) carries a word that either stores
// one descriptor (op write) or asks for a translation (op translate).
// Response channel (rsp_valid/rsp_ready/rsp) returns one word per translation:
// physical address, mapping kind and fault flag; writes return nothing.
// The APB port holds l1_table_base at byte address 0.
// A write leaves the walker idle and ready for the next request. A translation
// that ends at level one (section, supersection or fault) reads the level one
// entry and then registers its response; one that goes to a level two page
// reads the level two entry in between, so it makes two dependent reads of
// the descriptor memory.
// A new request is taken in the cycle after the response is registered, even
// if that response is still waiting; a stalled receiver holds the walker only
// once a second response is ready to be handed over.
// After reset the memory is swept to zero, one word a cycle, through all
// STORE_WORDS words (16384 by default); req_ready stays low during the sweep
// while the APB port works as usual.
// Depends on ptw_pkg, ptw_ctrl and ptw_dp.
module page_table_walk_short_descriptor #(
	parameter int unsigned STORE_WORDS = ptw_pkg::STORE_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ptw_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ptw_pkg::ptw_in_t            req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ptw_pkg::ptw_out_t           rsp
);
	import ptw_pkg::*;

	logic [L1_BASE_W-1:0] l1_base_q;
	logic                 sel_base;
	ptw_cmd_t             cmd;
	ptw_sts_t             sts;

	assign pready   = 1'b1;
	assign sel_base = (paddr[CFG_AW-1:2] == REG_L1_BASE);
	assign prdata   = sel_base ? 32'(l1_base_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_base_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_base) begin
			l1_base_q <= pwdata[L1_BASE_W-1:0];
		end
	end

	ptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ptw_dp #(
		.STORE_WORDS (STORE_WORDS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req     (req),
		.l1_base (l1_base_q),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

>>> hw/rtl/ptw_checker.sv
// port-level checks of the table walker, bound to the top level
// depends on ptw_pkg and the assertion macro header
`include "page_table_walk_short_descriptor_macros.svh"

module ptw_assert_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input ptw_pkg::ptw_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input ptw_pkg::ptw_out_t rsp
);
	import ptw_pkg::*;

	`PTW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled word changed")
	`PTW_ASSERT_NOW(a_fault_kind, rsp_valid, rsp.fault == (rsp.map_kind == KIND_FAULT), "fault flag disagrees with kind")
	`PTW_ASSERT_NOW(a_fault_zero, rsp_valid && rsp.fault, rsp.phys_addr == 32'd0, "fault word has nonzero address")
	`PTW_ASSERT_NEXT(a_write_silent, req_valid && req_ready && (req.op == OP_WRITE) && !rsp_valid, !rsp_valid, "write produced a response")

endmodule

bind page_table_walk_short_descriptor ptw_assert_checker u_ptw_checker (.*);
